/* rtl/ptcp_pkg.sv */
// Package with widths, register indexes and a saturation helper for the cylinder projection core.
package ptcp_pkg;

    // Coordinate format: signed Q(CW-FB).FB.
    localparam int CW    = 32;
    localparam int FB    = 16;

    // Offset from the axis point and its dot product with the direction.
    localparam int EW    = CW + 1;
    localparam int PW    = EW + CW;
    localparam int SW    = PW + 2;
    localparam int SMW   = SW - 1;
    localparam int SLW   = (SMW + 1) / 2;
    localparam int SHW   = SMW - SLW;
    localparam int DMW   = CW;
    localparam int N2W   = 2 * CW;

    // Foot division: numerator 2*|s|*|d_i| + n2, divisor 2*n2.
    localparam int TW    = SMW + DMW;
    localparam int NUM1W = TW + 2;
    localparam int D1W   = N2W + 1;
    localparam int QO    = CW + 3;
    localparam int OW    = QO + 1;

    // Radial offset v = e - off. Its magnitude never exceeds |e| < 2^(CW+1).
    localparam int VW    = OW + 1;
    localparam int VMW   = CW + 2;
    localparam int SSW   = 2 * VMW;

    // Square root of |v|^2 scaled by 4^FB.
    localparam int XW    = SSW + 2 * FB;
    localparam int NB    = XW / 2;

    // Radial step division: numerator 2*|v_i|*r*2^FB + N, divisor 2*N.
    localparam int VRW   = VMW + CW - 1;
    localparam int NUM2W = VRW + FB + 2;
    localparam int D2W   = NB + 1;
    localparam int QQ    = CW + 1;
    localparam int QW    = QQ + 1;

    // Final sum of axis point, foot offset and radial step.
    localparam int RW    = QW + 4;

    // Smallest |v|^2 in raw units that is not treated as lying on the axis.
    localparam longint unsigned ONE_E12 = 64'd1000000000000;
    localparam longint unsigned AXIS_THR =
        ((64'd1 << (2 * FB)) + ONE_E12 - 64'd1) / ONE_E12;

    localparam int CFG_IW = 3;

    typedef enum logic [CFG_IW-1:0] {
        REG_APX = 3'd0,
        REG_APY = 3'd1,
        REG_APZ = 3'd2,
        REG_ADX = 3'd3,
        REG_ADY = 3'd4,
        REG_ADZ = 3'd5,
        REG_RAD = 3'd6
    } t_reg_idx;

    // Clamp a wide signed sum to the signed coordinate range.
    function automatic logic [CW-1:0] sat_coord(input logic [RW-1:0] v);
        logic signed [RW-1:0] sv;
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        sv = $signed(v);
        hi = RW'((64'd1 << (CW - 1)) - 64'd1);
        lo = -hi - RW'(1);
        if (sv > hi) begin
            return hi[CW-1:0];
        end else if (sv < lo) begin
            return lo[CW-1:0];
        end
        return sv[CW-1:0];
    endfunction

endpackage

/* rtl/point_to_cylinder_projection_core.sv */
// Top level of the core that projects points radially onto a configured cylinder.
//
//  Channel   Handshake                     Payload
//  -------   ---------------------------   ---------------------------------------
//  in        i_in_valid / o_in_ready       i_point_x, i_point_y, i_point_z
//  out       o_out_valid / i_out_ready     o_proj_x, o_proj_y, o_proj_z
//  cfg       i_cfg_we (no handshake back)  i_cfg_idx, i_cfg_data
//
// The core takes one word per cycle while no output word waits untaken.
// Most of the pipeline lies in three bit-per-stage units: the foot division (35 stages),
// the square root of the offset length (50 stages) and the radial division (33).
// Reset is synchronous and active low; it clears all valid bits and loads the
// register defaults. When the output word is not taken, the whole pipeline holds
// and o_in_ready falls in the same cycle, so no word is lost or repeated.
// Words on the axis, or any word while the direction is zero, leave a bubble.
module point_to_cylinder_projection_core
    import ptcp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CW-1:0]     i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [CW-1:0]     i_point_x,
    input  logic [CW-1:0]     i_point_y,
    input  logic [CW-1:0]     i_point_z,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CW-1:0]     o_proj_x,
    output logic [CW-1:0]     o_proj_y,
    output logic [CW-1:0]     o_proj_z
);

    // Per-stage payloads of the three bit-serial units.
    typedef struct packed {
        logic [2:0]             neg;
        logic [2:0][EW-1:0]     e;
        logic [2:0][QO-1:0]     quo;
        logic [2:0][NUM1W-1:0]  rem;
    } t_dv1;

    typedef struct packed {
        logic [2:0][OW-1:0]     off;
        logic [2:0][VMW-1:0]    vm;
        logic [2:0]             vneg;
        logic [NB-1:0]          root;
        logic [XW:0]            rem;
    } t_sq;

    typedef struct packed {
        logic [2:0][OW-1:0]     off;
        logic [2:0]             vneg;
        logic [D2W-1:0]         d2;
        logic [2:0][QQ-1:0]     quo;
        logic [2:0][NUM2W-1:0]  rem;
    } t_dv2;

    // Configuration registers. The user must change them only while the pipeline
    // is empty; the block does not enforce this. Every stage reads them directly.
    logic [2:0][CW-1:0] r_c;
    logic [2:0][CW-1:0] r_d;
    logic [CW-2:0]      r_rad;

    // |d|^2 is rebuilt through r_dsq and r_n2 after a write, well before a new word
    // reaches the foot division.
    logic [2:0][N2W-1:0] r_dsq;
    logic [N2W-1:0]      r_n2;
    logic                w_dzero;
    logic [D1W-1:0]      w_d1;
    logic [2:0][DMW-1:0] w_dm;

    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c   <= '0;
            r_d   <= {CW'(1) << FB, CW'(0), CW'(0)};
            r_rad <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_APX: r_c[0] <= i_cfg_data;
                REG_APY: r_c[1] <= i_cfg_data;
                REG_APZ: r_c[2] <= i_cfg_data;
                REG_ADX: r_d[0] <= i_cfg_data;
                REG_ADY: r_d[1] <= i_cfg_data;
                REG_ADZ: r_d[2] <= i_cfg_data;
                REG_RAD: r_rad  <= i_cfg_data[CW-2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_dm[i] = r_d[i][CW-1] ? (~r_d[i] + CW'(1)) : r_d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_dsq[i] <= N2W'(w_dm[i]) * N2W'(w_dm[i]);
        end
        r_n2 <= r_dsq[0] + r_dsq[1] + r_dsq[2];
    end

    assign w_dzero = (r_d == '0);
    assign w_d1    = {r_n2, 1'b0};

    // The whole pipeline advances together unless the output word is stuck.
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    logic [2:0][CW-1:0] w_pt;
    assign w_pt = {i_point_z, i_point_y, i_point_x};

    // Front end: e = P - C, the products e_i*d_i, the dot product s, and the
    // two halves of |s|*|d_i|.
    logic                r_v1, r_v2, r_v3, r_v4;
    logic [2:0][EW-1:0]  r_e1, r_e2, r_e3, r_e4;
    logic [2:0][PW-1:0]  r_p2;
    logic [SW-1:0]       r_s3;
    logic                r_sneg4;
    logic [2:0][SLW+DMW-1:0] r_plo4;
    logic [2:0][SHW+DMW-1:0] r_phi4;
    logic [SMW-1:0]      w_sm;
    logic [SW-1:0]       w_sabs;

    assign w_sabs = r_s3[SW-1] ? (~r_s3 + SW'(1)) : r_s3;
    assign w_sm   = w_sabs[SMW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && !w_dzero;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EW'($signed(w_pt[i])) - EW'($signed(r_c[i]));
                r_p2[i] <= PW'($signed(r_e1[i])) * PW'($signed(r_d[i]));
                r_plo4[i] <= (SLW+DMW)'(w_sm[SLW-1:0]) * (SLW+DMW)'(w_dm[i]);
                r_phi4[i] <= (SHW+DMW)'(w_sm[SMW-1:SLW]) * (SHW+DMW)'(w_dm[i]);
            end
            r_e2    <= r_e1;
            r_s3    <= SW'($signed(r_p2[0])) + SW'($signed(r_p2[1]))
                     + SW'($signed(r_p2[2]));
            r_e3    <= r_e2;
            r_sneg4 <= r_s3[SW-1];
            r_e4    <= r_e3;
        end
    end

    // Foot division, one quotient bit per stage, rounding to nearest with
    // ties away from zero by dividing 2t + n2 by 2*n2.
    t_dv1          r_dv1 [QO+1];
    logic [QO:0]   r_vd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd1[0] <= 1'b0;
        end else if (en) begin
            r_vd1[0] <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv1[0].neg[i] <= r_sneg4 ^ r_d[i][CW-1];
                r_dv1[0].rem[i] <= ((NUM1W'(r_phi4[i]) << SLW) + NUM1W'(r_plo4[i]) << 1)
                                 + NUM1W'(r_n2);
            end
            r_dv1[0].e   <= r_e4;
            r_dv1[0].quo <= '0;
        end
    end

    genvar j;
    for (j = 0; j < QO; j++) begin : g_dv1
        t_dv1 n_s;
        always_comb begin
            n_s = r_dv1[j];
            for (int i = 0; i < 3; i++) begin
                if (r_dv1[j].rem[i] >= (NUM1W'(w_d1) << (QO - 1 - j))) begin
                    n_s.rem[i] = r_dv1[j].rem[i] - (NUM1W'(w_d1) << (QO - 1 - j));
                    n_s.quo[i][QO-1-j] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv1[j+1] <= n_s;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd1[j+1] <= 1'b0;
            end else if (en) begin
                r_vd1[j+1] <= r_vd1[j];
            end
        end
    end

    // Signed foot offset, radial offset v = e - off, and its square.
    logic                r_v6, r_v7, r_v8;
    logic [2:0][OW-1:0]  r_off6, r_off7, r_off8;
    logic [2:0][EW-1:0]  r_e6;
    logic [2:0][VW-1:0]  r_v7d;
    logic [2:0][VMW-1:0] r_vm8;
    logic [2:0]          r_vneg8;
    logic [2:0][SSW-1:0] r_vsq8;
    logic [2:0][VW-1:0]  w_vabs;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_vabs[i] = r_v7d[i][VW-1] ? (~r_v7d[i] + VW'(1)) : r_v7d[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (en) begin
            r_v6 <= r_vd1[QO];
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_off6[i] <= r_dv1[QO].neg[i] ? (~OW'(r_dv1[QO].quo[i]) + OW'(1))
                                              : OW'(r_dv1[QO].quo[i]);
                r_v7d[i]  <= VW'($signed(r_e6[i])) - VW'($signed(r_off6[i]));
                r_vm8[i]  <= w_vabs[i][VMW-1:0];
                r_vneg8[i] <= r_v7d[i][VW-1];
                r_vsq8[i] <= SSW'(w_vabs[i][VMW-1:0]) * SSW'(w_vabs[i][VMW-1:0]);
            end
            r_e6   <= r_dv1[QO].e;
            r_off7 <= r_off6;
            r_off8 <= r_off7;
        end
    end

    // Square root of |v|^2 * 4^FB, one root bit per stage. A point whose
    // offset is below the axis threshold is dropped on entry.
    t_sq           r_sq [NB+1];
    logic [NB:0]   r_vs;
    logic [SSW-1:0] w_sumsq;

    assign w_sumsq = r_vsq8[0] + r_vsq8[1] + r_vsq8[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs[0] <= 1'b0;
        end else if (en) begin
            r_vs[0] <= r_v8 && (w_sumsq >= SSW'(AXIS_THR));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq[0].off  <= r_off8;
            r_sq[0].vm   <= r_vm8;
            r_sq[0].vneg <= r_vneg8;
            r_sq[0].root <= '0;
            r_sq[0].rem  <= (XW+1)'(w_sumsq) << (2 * FB);
        end
    end

    for (j = 0; j < NB; j++) begin : g_sq
        t_sq          n_s;
        logic [XW:0]  w_trial;
        assign w_trial = ((XW+1)'(r_sq[j].root) << (NB - j))
                       + ((XW+1)'(1) << (2 * (NB - 1 - j)));
        always_comb begin
            n_s = r_sq[j];
            if (r_sq[j].rem >= w_trial) begin
                n_s.rem = r_sq[j].rem - w_trial;
                n_s.root[NB-1-j] = 1'b1;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[j+1] <= n_s;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vs[j+1] <= 1'b0;
            end else if (en) begin
                r_vs[j+1] <= r_vs[j];
            end
        end
    end

    // Radial step: |v_i| * r, then division by N with rounding as above.
    logic                r_v10;
    logic [2:0][VRW-1:0] r_vr10;
    logic [NB-1:0]       r_n10;
    logic [2:0][OW-1:0]  r_off10;
    logic [2:0]          r_vneg10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v10 <= 1'b0;
        end else if (en) begin
            r_v10 <= r_vs[NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_vr10[i] <= VRW'(r_sq[NB].vm[i]) * VRW'(r_rad);
            end
            r_n10    <= r_sq[NB].root;
            r_off10  <= r_sq[NB].off;
            r_vneg10 <= r_sq[NB].vneg;
        end
    end

    t_dv2          r_dv2 [QQ+1];
    logic [QQ:0]   r_vd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd2[0] <= 1'b0;
        end else if (en) begin
            r_vd2[0] <= r_v10;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv2[0].rem[i] <= (NUM2W'(r_vr10[i]) << (FB + 1)) + NUM2W'(r_n10);
            end
            r_dv2[0].quo  <= '0;
            r_dv2[0].d2   <= {r_n10, 1'b0};
            r_dv2[0].off  <= r_off10;
            r_dv2[0].vneg <= r_vneg10;
        end
    end

    for (j = 0; j < QQ; j++) begin : g_dv2
        t_dv2 n_s;
        always_comb begin
            n_s = r_dv2[j];
            for (int i = 0; i < 3; i++) begin
                if (r_dv2[j].rem[i] >= (NUM2W'(r_dv2[j].d2) << (QQ - 1 - j))) begin
                    n_s.rem[i] = r_dv2[j].rem[i] - (NUM2W'(r_dv2[j].d2) << (QQ - 1 - j));
                    n_s.quo[i][QQ-1-j] = 1'b1;
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv2[j+1] <= n_s;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd2[j+1] <= 1'b0;
            end else if (en) begin
                r_vd2[j+1] <= r_vd2[j];
            end
        end
    end

    // Signed radial step, then C + off + q with saturation into the output word.
    logic                r_v12;
    logic [2:0][QW-1:0]  r_q12;
    logic [2:0][OW-1:0]  r_off12;
    logic                r_out_vld;
    logic [2:0][CW-1:0]  r_proj;
    logic [2:0][RW-1:0]  w_sum;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = RW'($signed(r_c[i])) + RW'($signed(r_off12[i]))
                     + RW'($signed(r_q12[i]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v12     <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_v12     <= r_vd2[QQ];
            r_out_vld <= r_v12;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_q12[i] <= r_dv2[QQ].vneg[i] ? (~QW'(r_dv2[QQ].quo[i]) + QW'(1))
                                              : QW'(r_dv2[QQ].quo[i]);
                r_proj[i] <= sat_coord(w_sum[i]);
            end
            r_off12 <= r_dv2[QQ].off;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_proj_x    = r_proj[0];
    assign o_proj_y    = r_proj[1];
    assign o_proj_z    = r_proj[2];

endmodule
